/* design/lom_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_pkg: shared types and constants for the limit order matcher
// Book entry layout, action codes, datapath commands and default sizes.
// ----------------------------------------------------------------------------
package lom_pkg;

   localparam int BookDepthDefault    = 256;
   localparam int NumStocksDefault    = 5;
   localparam int PriceCeilingDefault = 1000000;

   localparam int IdW    = 20;
   localparam int StockW = 3;
   localparam int QtyW   = 20;
   localparam int PriceW = 20;

   localparam logic [1:0] ACT_BUY    = 2'd0;
   localparam logic [1:0] ACT_SELL   = 2'd1;
   localparam logic [1:0] ACT_CANCEL = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   // datapath commands issued by the controller
   localparam logic [2:0] C_NONE  = 3'd0;
   localparam logic [2:0] C_CLR   = 3'd1;  // clear best and free flags before a scan
   localparam logic [2:0] C_EVAL  = 3'd2;  // evaluate read data of the scan address
   localparam logic [2:0] C_FILL  = 3'd3;  // trade against best
   localparam logic [2:0] C_REST  = 3'd4;  // write remainder into free slot
   localparam logic [2:0] C_KILL  = 3'd5;  // cancel hit: invalidate
   localparam logic [2:0] C_QUERY = 3'd6;
   localparam logic [2:0] C_FULL  = 3'd7;

   // one resting order, packed for the book memories
   typedef struct packed {
      logic [IdW-1:0]    order_id;
      logic [StockW-1:0] stock;
      logic [QtyW-1:0]   quantity;
      logic [PriceW-1:0] price;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   typedef struct packed {
      logic [1:0]        action;
      logic [IdW-1:0]    order_id;
      logic [StockW-1:0] stock;
      logic [QtyW-1:0]   quantity;
      logic [PriceW-1:0] price;
   } req_type;

   typedef struct packed {
      logic [QtyW-1:0] value;
      logic            found;
      logic            book_full;
   } rsp_type;

endpackage

/* design/lom_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_req_if / lom_rsp_if: valid/ready channels
// Carry one request word or one result word per handshake.
// ----------------------------------------------------------------------------
interface lom_req_if;
   logic             valid;
   logic             ready;
   lom_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lom_rsp_if;
   logic             valid;
   logic             ready;
   lom_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/lom_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_ram: generic single port ram
// One read and an optional write per cycle, registered read data.
// ----------------------------------------------------------------------------
module lom_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

/* design/lom_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_datapath: books, valid bits, statistics and scan registers
// Executes the commands of the controller one step at a time.
// ----------------------------------------------------------------------------
module lom_datapath #(
   parameter int BookDepth    = lom_pkg::BookDepthDefault,
   parameter int NumStocks    = lom_pkg::NumStocksDefault,
   parameter int PriceCeiling = lom_pkg::PriceCeilingDefault,
   localparam int AW = $clog2(BookDepth)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            cmd,
   input  logic                  load,
   input  lom_pkg::req_type      req,
   input  logic [AW-1:0]         scan_addr,
   input  logic                  scan_book,   // 1: sell book
   output logic                  rem_zero,
   output logic                  have_best,
   output logic                  have_free,
   output logic                  found_hit,
   output lom_pkg::rsp_type      result
);
   lom_pkg::req_type req_ff;
   logic [lom_pkg::QtyW-1:0] rem_ff, rem_in;
   logic [BookDepth-1:0] bval_ff, sval_ff;
   logic [lom_pkg::PriceW-1:0] low_ff [NumStocks];
   logic [lom_pkg::PriceW-1:0] spr_ff [NumStocks];
   logic                 best_ok_ff, free_ok_ff, hit_ff, full_ff;
   logic [AW-1:0]        best_ff, free_ff, hit_addr_ff, eval_addr_ff;
   logic                 hit_book_ff;
   lom_pkg::entry_type   best_e_ff;

   // ram port control
   logic                 bwe, swe;
   logic [AW-1:0]        raddr;
   lom_pkg::entry_type   wentry, brd, srd, rd;
   logic                 is_buy;
   logic                 rd_valid, qualifies, better;
   logic [lom_pkg::StockW-1:0] sidx;
   logic                 stock_ok;
   logic [lom_pkg::PriceW-1:0] low_new;

   assign is_buy = (req_ff.action == lom_pkg::ACT_BUY);

   always_comb begin
      bwe = 1'b0;
      swe = 1'b0;
      raddr = scan_addr;
      wentry = best_e_ff;
      if (cmd == lom_pkg::C_FILL) begin
         raddr = best_ff;
         wentry.quantity = best_e_ff.quantity - rem_ff;
         if (is_buy) swe = 1'b1; else bwe = 1'b1;
      end else if (cmd == lom_pkg::C_REST) begin
         raddr = free_ff;
         wentry = '{order_id: req_ff.order_id, stock: req_ff.stock,
                    quantity: rem_ff, price: req_ff.price};
         if (is_buy) bwe = 1'b1; else swe = 1'b1;
      end
   end

   lom_ram #(.Width(lom_pkg::EntryW), .Depth(BookDepth)) u_buy (
      .clock(clock), .we(bwe), .addr(raddr), .wdata(wentry), .rdata(brd));
   lom_ram #(.Width(lom_pkg::EntryW), .Depth(BookDepth)) u_sell (
      .clock(clock), .we(swe), .addr(raddr), .wdata(wentry), .rdata(srd));

   // scan evaluation on registered read data
   assign rd = scan_book ? srd : brd;
   assign rd_valid = scan_book ? sval_ff[eval_addr_ff] : bval_ff[eval_addr_ff];
   always_comb begin
      qualifies = rd_valid && rd.stock == req_ff.stock &&
                  (is_buy ? rd.price <= req_ff.price : rd.price >= req_ff.price);
      if (!best_ok_ff) better = 1'b1;
      else if (rd.price == best_e_ff.price) better = rd.order_id < best_e_ff.order_id;
      else better = is_buy ? rd.price < best_e_ff.price : rd.price > best_e_ff.price;
   end

   assign stock_ok = req_ff.stock >= 1 &&
                     {29'd0, req_ff.stock} <= 32'(NumStocks);
   assign sidx = req_ff.stock - lom_pkg::StockW'(1);
   always_comb begin
      low_new = low_ff[sidx];
      if (best_e_ff.price < low_new) low_new = best_e_ff.price;
   end

   // remainder after a fill, or the profit for a query
   always_comb begin
      rem_in = rem_ff;
      if (cmd == lom_pkg::C_FILL)
         rem_in = (best_e_ff.quantity > rem_ff) ? '0 : rem_ff - best_e_ff.quantity;
      else if (cmd == lom_pkg::C_QUERY)
         rem_in = stock_ok ? spr_ff[sidx] : '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= req;
         rem_ff <= (req.action == lom_pkg::ACT_BUY || req.action == lom_pkg::ACT_SELL)
                   ? req.quantity : '0;
      end else begin
         rem_ff <= rem_in;
      end
      eval_addr_ff <= scan_addr;
      if (cmd == lom_pkg::C_EVAL) begin
         if (qualifies && better) begin
            best_ff    <= eval_addr_ff;
            best_e_ff  <= rd;
         end
         if (!rd_valid && !free_ok_ff)
            free_ff    <= eval_addr_ff;
         if (rd_valid && rd.order_id == req_ff.order_id && !hit_ff) begin
            hit_addr_ff <= eval_addr_ff;
            hit_book_ff <= scan_book;
         end
      end
   end

   // control flags, valid bits and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         bval_ff <= '0;
         sval_ff <= '0;
         best_ok_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         hit_ff <= 1'b0;
         full_ff <= 1'b0;
         for (int k = 0; k < NumStocks; k++) begin
            low_ff[k] <= lom_pkg::PriceW'(PriceCeiling);
            spr_ff[k] <= '0;
         end
      end else begin
         if (cmd == lom_pkg::C_CLR || cmd == lom_pkg::C_FILL) best_ok_ff <= 1'b0;
         else if (cmd == lom_pkg::C_EVAL && qualifies && better) best_ok_ff <= 1'b1;

         if (load || cmd == lom_pkg::C_CLR) free_ok_ff <= 1'b0;
         else if (cmd == lom_pkg::C_EVAL && !rd_valid) free_ok_ff <= 1'b1;

         if (load) hit_ff <= 1'b0;
         else if (cmd == lom_pkg::C_EVAL && rd_valid && rd.order_id == req_ff.order_id)
            hit_ff <= 1'b1;

         if (load) full_ff <= 1'b0;
         else if (cmd == lom_pkg::C_FULL) full_ff <= 1'b1;

         if (cmd == lom_pkg::C_FILL) begin
            if (best_e_ff.quantity <= rem_ff) begin
               if (is_buy) sval_ff[best_ff] <= 1'b0;
               else bval_ff[best_ff] <= 1'b0;
            end
            if (stock_ok) begin
               low_ff[sidx] <= low_new;
               if (best_e_ff.price - low_new > spr_ff[sidx])
                  spr_ff[sidx] <= best_e_ff.price - low_new;
            end
         end
         if (cmd == lom_pkg::C_REST) begin
            if (is_buy) bval_ff[free_ff] <= 1'b1;
            else sval_ff[free_ff] <= 1'b1;
         end
         if (cmd == lom_pkg::C_KILL) begin
            if (hit_book_ff) sval_ff[hit_addr_ff] <= 1'b0;
            else bval_ff[hit_addr_ff] <= 1'b0;
         end
      end
   end

   assign rem_zero  = (rem_ff == '0);
   assign have_best = best_ok_ff;
   assign have_free = free_ok_ff;
   assign found_hit = hit_ff;
   assign result = '{value: rem_ff, found: hit_ff && req_ff.action == lom_pkg::ACT_CANCEL,
                     book_full: full_ff};
endmodule

/* design/lom_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_ctrl: sequencer for the limit order matcher
// Drives book scans, fills, resting, cancels and the result handshake.
// ----------------------------------------------------------------------------
module lom_ctrl #(
   parameter int BookDepth = lom_pkg::BookDepthDefault,
   localparam int AW = $clog2(BookDepth)
) (
   input  logic          clock,
   input  logic          reset,
   lom_req_if.sink       req,
   lom_rsp_if.source     rsp,
   output logic [2:0]    cmd,
   output logic          load,
   output logic [AW-1:0] scan_addr,
   output logic          scan_book,
   input  logic          rem_zero,
   input  logic          have_best,
   input  logic          have_free,
   input  logic          found_hit,
   input  lom_pkg::rsp_type result
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MATCH = 3'd1;  // scan opposite book
   localparam logic [2:0] S_DEC   = 3'd2;  // fill, finish or go rest
   localparam logic [2:0] S_FREE  = 3'd3;  // scan own book for free slot
   localparam logic [2:0] S_PLACE = 3'd4;
   localparam logic [2:0] S_CAN   = 3'd5;  // scan buy book, then sell book if id not found
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW:0]   cnt_ff, cnt_in;     // issue count, runs to BookDepth to cover the registered read
   logic          book_ff, book_in;
   logic [1:0]    act_ff;
   logic          rsp_valid_ff;
   lom_pkg::rsp_type rsp_ff;
   logic          last_eval;
   logic          pend;

   // a pending result is flagged through bit 0 of the count while idle
   assign pend = (state_ff == S_IDLE) && cnt_ff[0];
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff && !cnt_ff[0];
   assign load = req.valid && req.ready;
   assign scan_addr = cnt_ff[AW-1:0];
   assign scan_book = book_ff;
   assign last_eval = (cnt_ff == (AW+1)'(BookDepth));

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      book_in = book_ff;
      cmd = lom_pkg::C_NONE;
      unique case (state_ff) inside
         S_IDLE: begin
            cnt_in = '0;
            if (load) begin
               unique case (req.payload.action) inside
                  lom_pkg::ACT_BUY, lom_pkg::ACT_SELL: begin
                     book_in = (req.payload.action == lom_pkg::ACT_BUY);
                     state_in = (req.payload.quantity == '0) ? S_OUT : S_MATCH;
                     cmd = lom_pkg::C_CLR;
                  end
                  lom_pkg::ACT_CANCEL: begin
                     book_in = 1'b0;
                     state_in = S_CAN;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_MATCH, S_FREE, S_CAN: begin
            if (cnt_ff != '0) cmd = lom_pkg::C_EVAL;
            cnt_in = cnt_ff + 1'b1;
            if (last_eval) begin
               cnt_in = '0;
               unique case (state_ff)
                  S_MATCH: state_in = S_DEC;
                  S_FREE:  state_in = S_PLACE;
                  default: begin
                     if (!book_ff && !found_hit) book_in = 1'b1;
                     else state_in = S_OUT;
                  end
               endcase
            end
         end
         S_DEC: begin
            if (have_best && !rem_zero) begin
               cmd = lom_pkg::C_FILL;
               state_in = S_MATCH;
            end else if (rem_zero) begin
               state_in = S_OUT;
            end else begin
               cmd = lom_pkg::C_CLR;
               book_in = !book_ff;
               state_in = S_FREE;
            end
         end
         S_PLACE: begin
            cmd = have_free ? lom_pkg::C_REST : lom_pkg::C_FULL;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (act_ff == lom_pkg::ACT_CANCEL && found_hit) cmd = lom_pkg::C_KILL;
            if (act_ff == lom_pkg::ACT_QUERY) cmd = lom_pkg::C_QUERY;
            cnt_in = (AW+1)'(1);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // result and valid are registered while the pending flag is set in idle
         if (pend) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      cnt_ff <= cnt_in;
      book_ff <= book_in;
      if (load) act_ff <= req.payload.action;
      if (pend) rsp_ff <= result;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
endmodule

/* design/limit_order_matcher.sv */
`timescale 1ns / 1ps
// from accept to result: a buy or sell scans the opposite book before each
// fill and once more, then its own book for a free slot when a remainder rests
// a cancel searches one or two books; a query scans no book
// throughput: one word in flight, the next accepted only once the result is taken
// reset: synchronous, clears valid bits and per-stock statistics at once
// ----------------------------------------------------------------------------
// limit_order_matcher: price-time priority order book, top level
// ----------------------------------------------------------------------------
module limit_order_matcher #(
   parameter int BookDepth    = lom_pkg::BookDepthDefault,
   parameter int NumStocks    = lom_pkg::NumStocksDefault,
   parameter int PriceCeiling = lom_pkg::PriceCeilingDefault
) (
   input logic   clock,
   input logic   reset,
   lom_req_if.sink   req,
   lom_rsp_if.source rsp
);
   localparam int AW = $clog2(BookDepth);
   logic [2:0] cmd;
   logic load, scan_book, rem_zero, have_best, have_free, found_hit;
   logic [AW-1:0] scan_addr;
   lom_pkg::rsp_type result;

   lom_ctrl #(.BookDepth(BookDepth)) u_ctrl (
      .clock, .reset, .req, .rsp, .cmd, .load, .scan_addr, .scan_book,
      .rem_zero, .have_best, .have_free, .found_hit, .result);

   lom_datapath #(.BookDepth(BookDepth), .NumStocks(NumStocks),
                  .PriceCeiling(PriceCeiling)) u_dp (
      .clock, .reset, .cmd, .load, .req(req.payload), .scan_addr, .scan_book,
      .rem_zero, .have_best, .have_free, .found_hit, .result);
endmodule

/* design/lom_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_checker: port level checks for the limit order matcher
// Watches the request and result channels.
// ----------------------------------------------------------------------------
module lom_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input lom_pkg::rsp_type rsp_payload
);
   // no new word while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   // accept is never followed directly by a result
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped");
   // found and book_full never together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.found && rsp_payload.book_full))
      else $error("found with book_full");
endmodule

bind limit_order_matcher lom_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));
